// ===== src/mdx_pkg.sv =====
// ----------------------------------------------------------------------------
// mdx_pkg: shared types for the mips decode and execute block
// Word formats on both channels, the decoded micro-op that crosses the
// queue, and the operation codes that the front end hands to the back end.
// ----------------------------------------------------------------------------
package mdx_pkg;

  // default depth of the queue between front end and back end
  localparam int MDX_QUEUE_DEPTH = 4;

  // input word: one instruction with its operands
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] rs_value;
    logic [31:0] rt_value;
    logic [31:0] pc;
  } mdx_in_t;

  // result word
  typedef struct packed {
    logic [31:0] result;
    logic [4:0]  dest_reg;
    logic        dest_wen;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] store_data;
    logic [31:0] next_pc;
    logic        redirect;
    logic        unsupported;
  } mdx_out_t;

  // alu operation picked by the decoder
  typedef enum logic [3:0] {
    ALU_ZERO,
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_NOR,
    ALU_SLT,
    ALU_SLTU,
    ALU_SLL,
    ALU_SRL,
    ALU_PASSB
  } mdx_alu_op_t;

  // control transfer kind
  typedef enum logic [2:0] {
    BR_NONE,
    BR_EQ,
    BR_NE,
    BR_JUMP,
    BR_JR
  } mdx_br_t;

  // decoded instruction, queued between front end and back end
  typedef struct packed {
    mdx_alu_op_t alu_op;
    mdx_br_t     br;
    logic [31:0] opa;
    logic [31:0] opb;
    logic [4:0]  shamt;
    logic [4:0]  dest_reg;
    logic        dest_wen;
    logic        mem_read;
    logic        mem_write;
    logic [31:0] store_data;
    logic        unsupported;
    logic [31:0] pc4;
    logic [31:0] target;
  } mdx_uop_t;

endpackage

// ===== src/mips_decode_and_execute_top.sv =====
// An accepted word is written into the decoded-word queue and is then executed
// from the queue head into the output register when nothing waits ahead of it.
// Throughput: one word per cycle, held up only by pop stalls; full rises once
// the decoded-word queue (QUEUE_DEPTH entries) and the output register fill.
// Reset: synchronous active-low rst_n empties the queue and the output register.
// ----------------------------------------------------------------------------
// mips_decode_and_execute_top: mips-32 subset decode and execute
// Front end decodes each instruction into a queue, the back end executes
// the queue head into an output register read as a queue.
// ----------------------------------------------------------------------------
module mips_decode_and_execute_top
  import mdx_pkg::*;
#(
  parameter int QUEUE_DEPTH = MDX_QUEUE_DEPTH
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  mdx_in_t  in_word,
  output logic     empty,
  input  logic     pop,
  output mdx_out_t out_word
);

  mdx_uop_t dec_uop;
  mdx_uop_t head_uop;
  logic     q_wr;
  logic     q_empty;
  logic     q_rd;

  // front end
  mdx_decode u_decode (
    .in_word (in_word),
    .uop     (dec_uop)
  );

  assign q_wr = push && !full;

  // queue between front end and back end
  mdx_uop_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr),
    .wr_data (dec_uop),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (head_uop),
    .empty   (q_empty)
  );

  // back end
  mdx_exec u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!q_empty),
    .head       (head_uop),
    .head_pop   (q_rd),
    .empty      (empty),
    .pop        (pop),
    .out_word   (out_word)
  );

endmodule

// ===== src/mdx_decode.sv =====
// ----------------------------------------------------------------------------
// mdx_decode: instruction classifier
// Splits the instruction into fields, picks the alu operation, the second
// operand, destination and memory flags, and works out pc+4 and the
// branch or jump target ahead of the back end.
// ----------------------------------------------------------------------------
module mdx_decode
  import mdx_pkg::*;
(
  input  mdx_in_t  in_word,
  output mdx_uop_t uop
);

  // opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTIU = 6'h0b;
  localparam logic [5:0] OP_ANDI  = 6'h0c;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // function codes of r-type
  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  localparam logic [4:0] LINK_REG = 5'd31;

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [15:0] imm;
  logic [31:0] seimm;
  logic [31:0] zimm;
  logic [31:0] pc4;
  logic [31:0] cond_target;
  logic [31:0] jmp_target;

  mdx_alu_op_t alu_op;
  mdx_br_t     br;
  logic [31:0] opb;
  logic [4:0]  dest;
  logic        wr;
  logic        mrd;
  logic        mwr;
  logic [31:0] sdata;
  logic        bad;

  // field split
  assign op    = in_word.instr_word[31:26];
  assign rt    = in_word.instr_word[20:16];
  assign rd    = in_word.instr_word[15:11];
  assign fn    = in_word.instr_word[5:0];
  assign imm   = in_word.instr_word[15:0];
  assign seimm = {{16{imm[15]}}, imm};
  assign zimm  = {16'd0, imm};

  // next-pc candidates
  assign pc4         = in_word.pc + 32'd4;
  assign cond_target = pc4 + {seimm[29:0], 2'b00};
  assign jmp_target  = {pc4[31:28], in_word.instr_word[25:0], 2'b00};

  // classification
  always_comb begin
    alu_op = ALU_ZERO;
    br     = BR_NONE;
    opb    = in_word.rt_value;
    dest   = 5'd0;
    wr     = 1'b0;
    mrd    = 1'b0;
    mwr    = 1'b0;
    sdata  = 32'd0;
    bad    = 1'b0;
    case (op)
      OP_RTYPE: begin
        dest = rd;
        wr   = 1'b1;
        case (fn)
          FN_ADD, FN_ADDU: alu_op = ALU_ADD;
          FN_SUB, FN_SUBU: alu_op = ALU_SUB;
          FN_AND:          alu_op = ALU_AND;
          FN_OR:           alu_op = ALU_OR;
          FN_NOR:          alu_op = ALU_NOR;
          FN_SLT:          alu_op = ALU_SLT;
          FN_SLTU:         alu_op = ALU_SLTU;
          FN_SLL:          alu_op = ALU_SLL;
          FN_SRL:          alu_op = ALU_SRL;
          FN_JR: begin
            dest = 5'd0;
            wr   = 1'b0;
            br   = BR_JR;
          end
          default: bad = 1'b1;
        endcase
      end
      OP_ADDIU: begin
        dest = rt; wr = 1'b1; alu_op = ALU_ADD; opb = seimm;
      end
      OP_ANDI: begin
        dest = rt; wr = 1'b1; alu_op = ALU_AND; opb = zimm;
      end
      OP_ORI: begin
        dest = rt; wr = 1'b1; alu_op = ALU_OR; opb = zimm;
      end
      OP_LUI: begin
        dest = rt; wr = 1'b1; alu_op = ALU_PASSB; opb = {imm, 16'd0};
      end
      OP_SLTIU: begin
        dest = rt; wr = 1'b1; alu_op = ALU_SLTU; opb = seimm;
      end
      OP_LW: begin
        dest = rt; wr = 1'b1; mrd = 1'b1; alu_op = ALU_ADD; opb = seimm;
      end
      OP_SW: begin
        mwr = 1'b1; alu_op = ALU_ADD; opb = seimm; sdata = in_word.rt_value;
      end
      OP_BEQ: br = BR_EQ;
      OP_BNE: br = BR_NE;
      OP_J:   br = BR_JUMP;
      OP_JAL: begin
        br = BR_JUMP; dest = LINK_REG; wr = 1'b1; alu_op = ALU_PASSB; opb = pc4;
      end
      default: bad = 1'b1;
    endcase
    // unsupported encodings leave no side effects
    if (bad) begin
      alu_op = ALU_ZERO;
      br     = BR_NONE;
      dest   = 5'd0;
      wr     = 1'b0;
      mrd    = 1'b0;
      mwr    = 1'b0;
      sdata  = 32'd0;
    end
  end

  // decoded word
  always_comb begin
    uop.alu_op      = alu_op;
    uop.br          = br;
    uop.opa         = in_word.rs_value;
    uop.opb         = opb;
    uop.shamt       = in_word.instr_word[10:6];
    uop.dest_reg    = dest;
    uop.dest_wen    = wr && (dest != 5'd0);
    uop.mem_read    = mrd;
    uop.mem_write   = mwr;
    uop.store_data  = sdata;
    uop.unsupported = bad;
    uop.pc4         = pc4;
    uop.target      = ((br == BR_EQ) || (br == BR_NE)) ? cond_target : jmp_target;
  end

endmodule

// ===== src/mdx_uop_queue.sv =====
// ----------------------------------------------------------------------------
// mdx_uop_queue: decoupling queue
// Small circular queue of decoded words between the front end and the
// back end; head entry is shown without delay.
// ----------------------------------------------------------------------------
module mdx_uop_queue
  import mdx_pkg::*;
#(
  parameter int DEPTH = MDX_QUEUE_DEPTH
)(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  mdx_uop_t wr_data,
  output logic     full,
  input  logic     rd_en,
  output mdx_uop_t rd_data,
  output logic     empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  mdx_uop_t           entries_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = entries_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== src/mdx_exec.sv =====
// ----------------------------------------------------------------------------
// mdx_exec: execute back end
// Runs the alu and resolves branches for the head of the queue, and
// holds the finished result word in an output register.
// ----------------------------------------------------------------------------
module mdx_exec
  import mdx_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     head_valid,
  input  mdx_uop_t head,
  output logic     head_pop,
  output logic     empty,
  input  logic     pop,
  output mdx_out_t out_word
);

  logic        out_valid_r, out_valid_nxt;
  mdx_out_t    out_word_r;
  mdx_out_t    res;
  logic [31:0] alu_y;
  logic        eq;

  // take the head whenever the output register is free or being drained
  assign head_pop      = head_valid && (!out_valid_r || pop);
  assign out_valid_nxt = head_pop || (out_valid_r && !pop);

  // alu
  always_comb begin
    case (head.alu_op)
      ALU_ADD:   alu_y = head.opa + head.opb;
      ALU_SUB:   alu_y = head.opa - head.opb;
      ALU_AND:   alu_y = head.opa & head.opb;
      ALU_OR:    alu_y = head.opa | head.opb;
      ALU_NOR:   alu_y = ~(head.opa | head.opb);
      ALU_SLT:   alu_y = {31'd0, ($signed(head.opa) < $signed(head.opb))};
      ALU_SLTU:  alu_y = {31'd0, (head.opa < head.opb)};
      ALU_SLL:   alu_y = head.opb << head.shamt;
      ALU_SRL:   alu_y = head.opb >> head.shamt;
      ALU_PASSB: alu_y = head.opb;
      default:   alu_y = 32'd0;
    endcase
  end

  // branch resolution and result assembly
  assign eq = (head.opa == head.opb);

  always_comb begin
    res.result      = alu_y;
    res.dest_reg    = head.dest_reg;
    res.dest_wen    = head.dest_wen;
    res.mem_read    = head.mem_read;
    res.mem_write   = head.mem_write;
    res.store_data  = head.store_data;
    res.unsupported = head.unsupported;
    res.next_pc     = head.pc4;
    res.redirect    = 1'b0;
    case (head.br)
      BR_EQ: begin
        if (eq) begin
          res.next_pc  = head.target;
          res.redirect = 1'b1;
        end
      end
      BR_NE: begin
        if (!eq) begin
          res.next_pc  = head.target;
          res.redirect = 1'b1;
        end
      end
      BR_JUMP: begin
        res.next_pc  = head.target;
        res.redirect = 1'b1;
      end
      BR_JR: begin
        res.next_pc  = head.opa;
        res.redirect = 1'b1;
      end
      default: ;
    endcase
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (head_pop) begin
      out_word_r <= res;
    end
  end

  assign empty    = !out_valid_r;
  assign out_word = out_word_r;

endmodule

// ===== src/mdx_checker.sv =====
// ----------------------------------------------------------------------------
// mdx_checker: port-level checks for the decode and execute block
// Watches both channels and flags words that break the block's rules.
// ----------------------------------------------------------------------------
module mdx_checker
  import mdx_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     push,
  input logic     full,
  input logic     empty,
  input logic     pop,
  input mdx_out_t out_word
);

  // nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result side not empty after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_word)))
    else $error("stalled result word changed");

  // an accepted word reaches the result side through the queue and the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full) |-> ##2 !empty)
    else $error("accepted word did not reach the result side");

  // unsupported encodings have no side effects
  a_bad_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_word.unsupported) |->
      (!out_word.dest_wen && !out_word.mem_read && !out_word.mem_write &&
       !out_word.redirect))
    else $error("unsupported word with side effects");

  // register zero is never written, loads and stores never mix
  a_dest: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (!(out_word.dest_wen && (out_word.dest_reg == 5'd0)) &&
                !(out_word.mem_read && out_word.mem_write)))
    else $error("bad destination or memory flags");

endmodule

bind mips_decode_and_execute_top mdx_checker u_mdx_checker (.*);
